>>> rtl/bzct_pkg.sv
// ============================================================================
// bzct_pkg
// Shared types, constants and commutation tables for the back-EMF
// zero-crossing commutation tracker.
// ============================================================================
package bzct_pkg;

    // Defaults for top-level parameters
    localparam int ADC_BITS_DEF    = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Field widths fixed by the interface
    localparam int TICK_W     = 16;
    localparam int THRESH_W   = 16;
    localparam int FACTOR_W   = 32;
    localparam int PHASE_W    = 3;
    localparam int STALLCNT_W = 6;
    localparam int PSUM_W     = 19;
    localparam int PCNT_W     = 3;
    localparam int NEUTRAL_W  = 16;   // widest neutral level carried in the queue
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FACTOR = 2'd2;

    // Configuration reset values
    localparam logic [THRESH_W-1:0] FILTER_THRESH_RST = 16'd4;
    localparam logic [FACTOR_W-1:0] SPEED_FACTOR_RST  = 32'd1000000;

    // Sample channel codes
    localparam logic [1:0] CH_U = 2'd0;
    localparam logic [1:0] CH_V = 2'd1;
    localparam logic [1:0] CH_W = 2'd2;

    // Commutation steps
    localparam logic [PHASE_W-1:0] STEP_FIRST = 3'd0;
    localparam logic [PHASE_W-1:0] STEP_LAST  = 3'd5;

    // Limits
    localparam logic [THRESH_W-1:0]   FILTER_MAX  = 16'hFFFF;
    localparam logic [THRESH_W-1:0]   QUICK_LIMIT = 16'd12;
    localparam logic [STALLCNT_W-1:0] STALL_MAX   = 6'd63;
    localparam logic [STALLCNT_W-1:0] SHUT_LIMIT  = 6'd50;
    localparam logic [TICK_W-1:0]     RELOAD_TOP  = 16'hFFFF;

    // Command handed from the classifier to the period/speed engine
    typedef struct packed {
        logic                  zero_cross;
        logic                  stall_shutdown;
        logic [PHASE_W-1:0]    phase;
        logic [TICK_W-1:0]     ticks;
        logic [NEUTRAL_W-1:0]  neutral;
    } t_cmd;

    // Channel expected to cross at a step, per direction
    function automatic logic [1:0] f_cross_chan(input logic dir,
                                                input logic [PHASE_W-1:0] step);
        logic [1:0] ch;
        ch = CH_W;
        case (step)
            3'd0, 3'd3: ch = CH_W;
            3'd1, 3'd4: ch = dir ? CH_U : CH_V;
            3'd2, 3'd5: ch = dir ? CH_V : CH_U;
            default:    ch = CH_W;
        endcase
        return ch;
    endfunction

    // 1: expect the level to rise above neutral, 0: to fall below it
    function automatic logic f_cross_above(input logic dir,
                                           input logic [PHASE_W-1:0] step);
        return step[0] ^ dir;
    endfunction

endpackage

>>> rtl/bzct_front.sv
// ============================================================================
// bzct_front
// Accept ADC events, store the sample, form the neutral level and test for
// the expected crossing; push one command per event into the queue.
// ============================================================================
module bzct_front #(
    parameter int ADC_BITS = bzct_pkg::ADC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ADC_BITS-1:0]             i_bemf_sample,
    input  logic                            i_run_mode,
    input  logic [bzct_pkg::TICK_W-1:0]     i_elapsed_ticks,
    input  logic                            i_direction,
    input  logic [bzct_pkg::THRESH_W-1:0]   i_filter_threshold,
    output logic                            o_push,
    input  logic                            i_full,
    output bzct_pkg::t_cmd                  o_cmd
);

    localparam int SUM_W    = ADC_BITS + 2;
    localparam int RECIP_SH = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_SH;
    // ceil(2^RECIP_SH / 3): exact floor(sum/3) for every sum below 2^SUM_W
    localparam logic [PROD_W-1:0] RECIP =
        PROD_W'(((64'd1 << RECIP_SH) + 64'd2) / 64'd3);

    typedef enum logic [1:0] {S_IDLE, S_SUM, S_MUL, S_EVAL} t_state;

    t_state                          r_state;
    logic [1:0]                      r_chan;
    logic [ADC_BITS-1:0]             r_u, r_v, r_w;
    logic [SUM_W-1:0]                r_sum;
    logic [ADC_BITS-1:0]             r_neutral;
    logic                            r_run;
    logic [bzct_pkg::TICK_W-1:0]     r_ticks;
    logic [bzct_pkg::THRESH_W-1:0]   r_filt;
    logic [bzct_pkg::PHASE_W-1:0]    r_phase;
    logic [bzct_pkg::STALLCNT_W-1:0] r_stall_cnt;

    logic [PROD_W-1:0]               w_prod;
    logic [bzct_pkg::THRESH_W-1:0]   w_filt_inc;
    logic                            w_test;
    logic                            w_bad_step;
    logic [1:0]                      w_ch;
    logic [ADC_BITS-1:0]             w_lvl;
    logic                            w_hit;
    logic                            w_cross;
    logic                            w_quick;
    logic [bzct_pkg::PHASE_W-1:0]    n_phase;
    logic [bzct_pkg::STALLCNT_W-1:0] n_stall_cnt;
    logic [bzct_pkg::THRESH_W-1:0]   n_filt;
    logic                            w_shut;

    assign o_stall = (r_state != S_IDLE);
    assign w_prod  = PROD_W'(r_sum) * RECIP;

    always_comb begin
        w_filt_inc = (r_filt == bzct_pkg::FILTER_MAX) ? r_filt : r_filt + 1'b1;
        w_test     = r_run && (w_filt_inc >= i_filter_threshold);
        w_bad_step = (r_phase > bzct_pkg::STEP_LAST);
        w_ch       = bzct_pkg::f_cross_chan(i_direction, r_phase);
        case (w_ch)
            bzct_pkg::CH_U: w_lvl = r_u;
            bzct_pkg::CH_V: w_lvl = r_v;
            default:        w_lvl = r_w;
        endcase
        w_hit   = bzct_pkg::f_cross_above(i_direction, r_phase) ? (w_lvl > r_neutral)
                                                                 : (w_lvl < r_neutral);
        w_cross = w_test && !w_bad_step && w_hit;
        w_quick = (w_filt_inc <= bzct_pkg::QUICK_LIMIT);

        n_phase = r_phase;
        if (w_cross) begin
            n_phase = (r_phase == bzct_pkg::STEP_LAST) ? bzct_pkg::STEP_FIRST
                                                       : r_phase + 1'b1;
        end else if (w_test && w_bad_step) begin
            n_phase = bzct_pkg::STEP_FIRST;
        end

        n_stall_cnt = r_stall_cnt;
        if (w_cross) begin
            if (!w_quick) begin
                n_stall_cnt = '0;
            end else if (r_stall_cnt != bzct_pkg::STALL_MAX) begin
                n_stall_cnt = r_stall_cnt + 1'b1;
            end
        end
        w_shut = w_cross && w_quick && (n_stall_cnt >= bzct_pkg::SHUT_LIMIT);

        n_filt = r_filt;
        if (r_run) begin
            n_filt = w_cross ? '0 : w_filt_inc;
        end
    end

    assign o_push               = (r_state == S_EVAL) && !i_full;
    assign o_cmd.zero_cross     = w_cross;
    assign o_cmd.stall_shutdown = w_shut;
    assign o_cmd.phase          = n_phase;
    assign o_cmd.ticks          = r_ticks;
    assign o_cmd.neutral        = bzct_pkg::NEUTRAL_W'(r_neutral);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chan      <= bzct_pkg::CH_U;
            r_u         <= '0;
            r_v         <= '0;
            r_w         <= '0;
            r_filt      <= '0;
            r_phase     <= bzct_pkg::STEP_FIRST;
            r_stall_cnt <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_run   <= i_run_mode;
                        r_ticks <= i_elapsed_ticks;
                        case (r_chan)
                            bzct_pkg::CH_U: begin
                                r_u    <= i_bemf_sample;
                                r_chan <= bzct_pkg::CH_V;
                            end
                            bzct_pkg::CH_V: begin
                                r_v    <= i_bemf_sample;
                                r_chan <= bzct_pkg::CH_W;
                            end
                            bzct_pkg::CH_W: begin
                                r_w    <= i_bemf_sample;
                                r_chan <= bzct_pkg::CH_U;
                            end
                            default: r_chan <= bzct_pkg::CH_U;
                        endcase
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sum   <= SUM_W'(r_u) + SUM_W'(r_v) + SUM_W'(r_w);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_neutral <= w_prod[RECIP_SH +: ADC_BITS];
                    r_state   <= S_EVAL;
                end
                S_EVAL: begin
                    // hold until the queue has room
                    if (!i_full) begin
                        r_phase     <= n_phase;
                        r_stall_cnt <= n_stall_cnt;
                        r_filt      <= n_filt;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/bzct_queue.sv
// ============================================================================
// bzct_queue
// Small register FIFO of commands between the classifier and the engine.
// ============================================================================
module bzct_queue #(
    parameter int DEPTH = bzct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bzct_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output bzct_pkg::t_cmd  o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    bzct_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/bzct_back.sv
// ============================================================================
// bzct_back
// Carry out crossings: delay reload, eight-crossing period average and a
// bit-serial speed division; drive the registered result channel.
// ============================================================================
module bzct_back #(
    parameter int ADC_BITS = bzct_pkg::ADC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  bzct_pkg::t_cmd                  i_cmd,
    output logic                            o_pop,
    input  logic [bzct_pkg::FACTOR_W-1:0]   i_speed_factor,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_zero_cross,
    output logic [bzct_pkg::PHASE_W-1:0]    o_phase,
    output logic [bzct_pkg::TICK_W-1:0]     o_delay_reload,
    output logic [bzct_pkg::TICK_W-1:0]     o_speed_period,
    output logic [bzct_pkg::FACTOR_W-1:0]   o_speed,
    output logic                            o_stall_shutdown,
    output logic [ADC_BITS-1:0]             o_neutral_level
);

    localparam int BIT_W = $clog2(bzct_pkg::FACTOR_W);
    localparam int REM_W = bzct_pkg::TICK_W;

    typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} t_state;

    t_state                          r_state;
    bzct_pkg::t_cmd                  r_cmd;
    logic [bzct_pkg::TICK_W-1:0]     r_reload;
    logic [bzct_pkg::PSUM_W-1:0]     r_psum;
    logic [bzct_pkg::PCNT_W-1:0]     r_pcnt;
    logic [bzct_pkg::TICK_W-1:0]     r_avg;
    logic [bzct_pkg::FACTOR_W-1:0]   r_speed;
    logic [bzct_pkg::TICK_W-1:0]     r_div_d;
    logic [bzct_pkg::FACTOR_W-1:0]   r_div_q;
    logic [REM_W-1:0]                r_div_rem;
    logic [BIT_W-1:0]                r_div_bit;
    logic                            r_o_valid;

    logic [bzct_pkg::PSUM_W-1:0]     n_psum;
    logic [bzct_pkg::TICK_W-1:0]     n_avg;
    logic [bzct_pkg::TICK_W-1:0]     w_divisor;
    logic [REM_W:0]                  w_trial;
    logic                            w_fit;
    logic                            w_out_free;

    assign o_pop      = (r_state == B_IDLE) && i_cmd_valid;
    assign w_out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_psum    = r_psum + bzct_pkg::PSUM_W'(i_cmd.ticks);
        n_avg     = (r_pcnt == '1) ? n_psum[3 +: bzct_pkg::TICK_W] : r_avg;
        w_divisor = (n_avg != '0) ? n_avg : i_cmd.ticks;
        w_trial   = {r_div_rem, r_div_q[bzct_pkg::FACTOR_W-1]};
        w_fit     = (w_trial >= {1'b0, r_div_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_reload  <= '0;
            r_psum    <= '0;
            r_pcnt    <= '0;
            r_avg     <= '0;
            r_speed   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall && (r_state != B_OUT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.zero_cross) begin
                            r_reload <= bzct_pkg::RELOAD_TOP - (i_cmd.ticks >> 3);
                            r_avg    <= n_avg;
                            r_pcnt   <= r_pcnt + 1'b1;
                            r_psum   <= (r_pcnt == '1) ? '0 : n_psum;
                            // a zero divisor runs out as all ones: saturated speed
                            r_div_d   <= w_divisor;
                            r_div_q   <= i_speed_factor;
                            r_div_rem <= '0;
                            r_div_bit <= '1;
                            r_state   <= B_DIV;
                        end else begin
                            r_state <= B_OUT;
                        end
                    end
                end
                B_DIV: begin
                    r_div_rem <= w_fit ? REM_W'(w_trial - {1'b0, r_div_d})
                                       : w_trial[REM_W-1:0];
                    r_div_q   <= {r_div_q[bzct_pkg::FACTOR_W-2:0], w_fit};
                    r_div_bit <= r_div_bit - 1'b1;
                    if (r_div_bit == '0) begin
                        r_speed <= {r_div_q[bzct_pkg::FACTOR_W-2:0], w_fit};
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    // hold the result until the output register frees up
                    if (w_out_free) begin
                        o_zero_cross     <= r_cmd.zero_cross;
                        o_phase          <= r_cmd.phase;
                        o_delay_reload   <= r_reload;
                        o_speed_period   <= r_avg;
                        o_speed          <= r_speed;
                        o_stall_shutdown <= r_cmd.stall_shutdown;
                        o_neutral_level  <= r_cmd.neutral[ADC_BITS-1:0];
                        r_o_valid        <= 1'b1;
                        r_state          <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid = r_o_valid;

endmodule

>>> rtl/bemf_zero_cross_commutation_tracker.sv
// ============================================================================
// bemf_zero_cross_commutation_tracker
// Sensorless six-step commutation tracker driven by back-EMF ADC events.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one ADC event per
//   transaction: sample, run flag and timer ticks. Output channel
//   (o_out_valid / i_out_stall) returns exactly one result transaction per
//   event, in order. Configuration is a plain write port (i_cfg_we,
//   i_cfg_index, i_cfg_data); write it only while the block is idle.
//   Flow: the classifier stores the event, sums the three samples, forms
//   the neutral level, then tests and pushes the command; the engine
//   registers the result, after a serial speed division for a crossing.
//   The classifier takes no new event until its command is pushed. A
//   crossing occupies the engine in the one-bit-per-cycle speed divider;
//   the command queue lets the classifier take further events meanwhile.
//   Reset: all control and tracking state clears, configuration returns to
//   clockwise, threshold 4, speed factor 1000000.
//   Receiver stall: the result register holds; the engine waits, the queue
//   fills, and then o_in_stall stays high until results drain.
// ============================================================================
module bemf_zero_cross_commutation_tracker #(
    parameter int ADC_BITS    = bzct_pkg::ADC_BITS_DEF,
    parameter int QUEUE_DEPTH = bzct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // event channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [ADC_BITS-1:0]              i_bemf_sample,
    input  logic                             i_run_mode,
    input  logic [bzct_pkg::TICK_W-1:0]      i_elapsed_ticks,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_zero_cross,
    output logic [bzct_pkg::PHASE_W-1:0]     o_phase,
    output logic [bzct_pkg::TICK_W-1:0]      o_delay_reload,
    output logic [bzct_pkg::TICK_W-1:0]      o_speed_period,
    output logic [bzct_pkg::FACTOR_W-1:0]    o_speed,
    output logic                             o_stall_shutdown,
    output logic [ADC_BITS-1:0]              o_neutral_level,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [bzct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bzct_pkg::FACTOR_W-1:0]    i_cfg_data
);

    // Configuration registers
    logic                             r_direction;
    logic [bzct_pkg::THRESH_W-1:0]    r_filter_threshold;
    logic [bzct_pkg::FACTOR_W-1:0]    r_speed_factor;

    // Classifier to queue to engine
    logic                             w_push;
    logic                             w_full;
    bzct_pkg::t_cmd                   w_push_cmd;
    logic                             w_pop;
    logic                             w_cmd_valid;
    bzct_pkg::t_cmd                   w_head_cmd;

    // Write a register on enable; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction        <= 1'b0;
            r_filter_threshold <= bzct_pkg::FILTER_THRESH_RST;
            r_speed_factor     <= bzct_pkg::SPEED_FACTOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bzct_pkg::CFG_DIRECTION:
                    r_direction <= i_cfg_data[0];
                bzct_pkg::CFG_FILTER_THRESH:
                    r_filter_threshold <= i_cfg_data[bzct_pkg::THRESH_W-1:0];
                bzct_pkg::CFG_SPEED_FACTOR:
                    r_speed_factor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classifier: sample store, neutral level, crossing test, stall count
    bzct_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .o_stall            (o_in_stall),
        .i_bemf_sample      (i_bemf_sample),
        .i_run_mode         (i_run_mode),
        .i_elapsed_ticks    (i_elapsed_ticks),
        .i_direction        (r_direction),
        .i_filter_threshold (r_filter_threshold),
        .o_push             (w_push),
        .i_full             (w_full),
        .o_cmd              (w_push_cmd)
    );

    // Decouple the classifier from the slow speed engine
    bzct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_head_cmd)
    );

    // Engine: reload, period average, speed division, result register
    bzct_back #(
        .ADC_BITS (ADC_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (w_cmd_valid),
        .i_cmd            (w_head_cmd),
        .o_pop            (w_pop),
        .i_speed_factor   (r_speed_factor),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_zero_cross     (o_zero_cross),
        .o_phase          (o_phase),
        .o_delay_reload   (o_delay_reload),
        .o_speed_period   (o_speed_period),
        .o_speed          (o_speed),
        .o_stall_shutdown (o_stall_shutdown),
        .o_neutral_level  (o_neutral_level)
    );

endmodule
